// ===== sv/ecmc_pkg.sv =====
// Shared types and codes for the encoder counted motion controller.
// No dependencies; imported by ecmc_core and the top level.
package ecmc_pkg;

    // item opcodes
    localparam logic [2:0] OP_ROT_L  = 3'd0;
    localparam logic [2:0] OP_ROT_R  = 3'd1;
    localparam logic [2:0] OP_FWD    = 3'd2;
    localparam logic [2:0] OP_PIV_L  = 3'd3;
    localparam logic [2:0] OP_PIV_R  = 3'd4;
    localparam logic [2:0] OP_PULSE_L = 3'd5;
    localparam logic [2:0] OP_PULSE_R = 3'd6;
    localparam logic [2:0] OP_ABORT  = 3'd7;

    // move modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_ROT_L = 3'd1;
    localparam logic [2:0] MODE_ROT_R = 3'd2;
    localparam logic [2:0] MODE_FWD   = 3'd3;
    localparam logic [2:0] MODE_PIV_L = 3'd4;
    localparam logic [2:0] MODE_PIV_R = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNTS_PER_DEG = 2'd0;
    localparam logic [1:0] CFG_COUNTS_PER_CM  = 2'd1;
    localparam logic [1:0] CFG_LEFT_TRIM      = 2'd2;

    localparam logic [3:0]  CPD_RESET  = 4'd2;
    localparam logic [15:0] CPCM_RESET = 16'd4191;  // ~16.3711 in Q8.8
    localparam logic [9:0]  TRIM_RESET = 10'd80;

    typedef struct packed {
        logic [3:0]  counts_per_degree;
        logic [15:0] counts_per_cm_q8;
        logic [9:0]  left_trim;
    } cfg_t;

    // left_duty sits in the lowest bits
    typedef struct packed {
        logic        done_res;
        logic        busy_res;
        logic        drive_enable;
        logic        right_reverse;
        logic        left_reverse;
        logic [15:0] right_duty;
        logic [15:0] left_duty;
    } result_t;

endpackage

// ===== sv/ecmc_core.sv =====
// Move state, pulse counters and end-of-move test for one item per cycle while fire is high.
// Depends on ecmc_pkg.
module ecmc_core
    import ecmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  logic [2:0]       opcode,
    input  logic [15:0]      speed,
    input  logic [11:0]      amount,
    input  cfg_t             cfg,
    output result_t          res
);

    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [COUNT_WIDTH-1:0] left_pulses_reg, left_pulses_next;
    logic [COUNT_WIDTH-1:0] right_pulses_reg, right_pulses_next;
    logic [COUNT_WIDTH-1:0] target_reg, target_next;
    logic [2:0]             mode_reg, mode_next;
    logic [15:0]            left_duty_reg, left_duty_next;
    logic [15:0]            right_duty_reg, right_duty_next;
    logic [1:0]             dir_reg, dir_next;      // bit0 left, bit1 right reverse
    logic                   enable_reg, enable_next;

    logic [15:0]            prod_deg;
    logic [27:0]            prod_cm;
    logic [COUNT_WIDTH-1:0] tgt_deg, tgt_cm;
    logic                   is_cmd;
    logic                   left_over, right_over, fin;

    function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [31:0] v);
        logic [32:0] w;
        w = {1'b0, v};
        if (w > CNT_MAX)
            sat_count = CNT_MAX[COUNT_WIDTH-1:0];
        else
            sat_count = w[COUNT_WIDTH-1:0];
    endfunction

    assign prod_deg = {4'd0, amount} * {12'd0, cfg.counts_per_degree};
    assign prod_cm  = {16'd0, amount} * {12'd0, cfg.counts_per_cm_q8};
    assign tgt_deg  = sat_count({16'd0, prod_deg});
    assign tgt_cm   = sat_count({12'd0, prod_cm[27:8]});
    assign is_cmd   = (opcode == OP_ROT_L) || (opcode == OP_ROT_R) || (opcode == OP_FWD)
                   || (opcode == OP_PIV_L) || (opcode == OP_PIV_R);

    always_comb begin
        left_pulses_next  = left_pulses_reg;
        right_pulses_next = right_pulses_reg;
        target_next       = target_reg;
        mode_next         = mode_reg;
        left_duty_next    = left_duty_reg;
        right_duty_next   = right_duty_reg;
        dir_next          = dir_reg;
        enable_next       = enable_reg;

        if (is_cmd) begin
            left_pulses_next  = '0;
            right_pulses_next = '0;
            enable_next       = 1'b1;
        end

        case (opcode)
            OP_ROT_L: begin
                mode_next       = MODE_ROT_L;
                dir_next        = 2'b01;
                left_duty_next  = speed;
                right_duty_next = speed;
                target_next     = tgt_deg;
            end
            OP_ROT_R: begin
                mode_next       = MODE_ROT_R;
                dir_next        = 2'b10;
                left_duty_next  = speed;
                right_duty_next = speed;
                target_next     = tgt_deg;
            end
            OP_FWD: begin
                mode_next       = MODE_FWD;
                dir_next        = 2'b00;
                left_duty_next  = speed + {6'd0, cfg.left_trim};
                right_duty_next = speed;
                target_next     = tgt_cm;
            end
            OP_PIV_L: begin
                mode_next       = MODE_PIV_L;
                dir_next        = 2'b00;
                left_duty_next  = speed;
                right_duty_next = 16'd0;
                target_next     = tgt_cm;
            end
            OP_PIV_R: begin
                mode_next       = MODE_PIV_R;
                dir_next        = 2'b00;
                left_duty_next  = 16'd0;
                right_duty_next = speed;
                target_next     = tgt_cm;
            end
            OP_PULSE_L: begin
                if (!(&left_pulses_reg))
                    left_pulses_next = left_pulses_reg + CNT_ONE;
            end
            OP_PULSE_R: begin
                if (!(&right_pulses_reg))
                    right_pulses_next = right_pulses_reg + CNT_ONE;
            end
            default: begin
                mode_next       = MODE_IDLE;
                left_duty_next  = 16'd0;
                right_duty_next = 16'd0;
            end
        endcase

        // a fresh command has zero counts and cannot finish on its own beat,
        // so the test only needs the stored target
        left_over  = left_pulses_next > target_reg;
        right_over = right_pulses_next > target_reg;
        fin        = 1'b0;
        if (!is_cmd && (mode_next != MODE_IDLE)) begin
            if (mode_next == MODE_PIV_L)
                fin = left_over;
            else if (mode_next == MODE_PIV_R)
                fin = right_over;
            else
                fin = left_over && right_over;
        end
        if (fin) begin
            mode_next       = MODE_IDLE;
            left_duty_next  = 16'd0;
            right_duty_next = 16'd0;
        end

        res.left_duty     = left_duty_next;
        res.right_duty    = right_duty_next;
        res.left_reverse  = dir_next[0];
        res.right_reverse = dir_next[1];
        res.drive_enable  = enable_next;
        res.busy_res      = (mode_next != MODE_IDLE);
        res.done_res      = fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_pulses_reg  <= '0;
            right_pulses_reg <= '0;
            target_reg       <= '0;
            mode_reg         <= MODE_IDLE;
            left_duty_reg    <= 16'd0;
            right_duty_reg   <= 16'd0;
            dir_reg          <= 2'b00;
            enable_reg       <= 1'b0;
        end else if (fire) begin
            left_pulses_reg  <= left_pulses_next;
            right_pulses_reg <= right_pulses_next;
            target_reg       <= target_next;
            mode_reg         <= mode_next;
            left_duty_reg    <= left_duty_next;
            right_duty_reg   <= right_duty_next;
            dir_reg          <= dir_next;
            enable_reg       <= enable_next;
        end
    end

    a_cmd_clears_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_cmd |=> left_pulses_reg == '0 && right_pulses_reg == '0)
        else $error("pulse counts not cleared by a command");

    a_abort_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && opcode == OP_ABORT |=> mode_reg == MODE_IDLE
            && left_duty_reg == 16'd0 && right_duty_reg == 16'd0)
        else $error("abort left the wheels driven");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.done_res |-> !res.busy_res && res.left_duty == 16'd0
            && res.right_duty == 16'd0)
        else $error("done flagged while still driving");

    a_enable_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        enable_reg |=> enable_reg)
        else $error("drive enable dropped");

    a_no_done_on_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && is_cmd |-> !res.done_res && res.busy_res)
        else $error("command beat finished immediately");

endmodule

// ===== sv/encoder_counted_motion_control.sv =====
// Encoder counted motion controller: an input beat reaches the result beat through
// the input register, then the state update into the result register.
// Throughput one beat per cycle unless m_tready stalls the result stage; the move state is updated once per beat.
// Reset (aresetn low, synchronous) clears both stages, the move state and counts,
// and returns the configuration registers to their defaults.
// Depends on ecmc_pkg and ecmc_core.
module encoder_counted_motion_control
    import ecmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // speed[15:0], amount[27:16], zero pad
    input  logic [2:0]  s_tuser,    // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[15:0], right_duty[31:16], left_reverse[32], right_reverse[33],
    // drive_enable[34], busy_res[35], done_res[36], zero pad
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [2:0]  opcode_reg;
    logic [15:0] speed_reg;
    logic [11:0] amount_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.counts_per_degree <= CPD_RESET;
            cfg_reg.counts_per_cm_q8  <= CPCM_RESET;
            cfg_reg.left_trim         <= TRIM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_COUNTS_PER_DEG: cfg_reg.counts_per_degree <= cfg_data[3:0];
                CFG_COUNTS_PER_CM:  cfg_reg.counts_per_cm_q8  <= cfg_data;
                CFG_LEFT_TRIM:      cfg_reg.left_trim         <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            opcode_reg <= s_tuser;
            speed_reg  <= s_tdata[15:0];
            amount_reg <= s_tdata[27:16];
        end
    end

    ecmc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .opcode  (opcode_reg),
        .speed   (speed_reg),
        .amount  (amount_reg),
        .cfg     (cfg_reg),
        .res     (res_next)
    );

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (fire)
            res_reg <= res_next;
    end

endmodule
